// File: src/kxld_pkg.sv
// Package for the keyed XOR line decoder: shared types, constants and the key
// byte select. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kxld_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int KEY_IDX_W   = $clog2(KEY_BYTES);
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int KEY_STEP    = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;

  // Register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_TEXT_KEY_LOW     = 3'd0;
  localparam logic [2:0] REG_TEXT_KEY_HIGH    = 3'd1;
  localparam logic [2:0] REG_COMMENT_KEY_LOW  = 3'd2;
  localparam logic [2:0] REG_COMMENT_KEY_HIGH = 3'd3;
  localparam logic [2:0] REG_COMMENT_ENABLE   = 3'd4;

  localparam logic [7:0] CHAR_MARKER = 8'h40;  // '@'
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;  // '/'
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CODE_TAB    = 8'h9f;
  localparam logic [7:0] CODE_SPACE  = 8'h80;
  localparam logic [7:0] TEXT_BASE   = 8'h20;
  localparam logic [7:0] TEXT_MASK   = 8'h7f;

  typedef struct packed {
    logic [KEY_W-1:0] text_key;
    logic [KEY_W-1:0] comment_key;
    logic             comment_enable;
  } cfg_t;

  // One classified word handed from the front to the back
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 decode;
    logic                 fresh;    // first decoded byte of the line
    logic [KEY_IDX_W-1:0] key_idx;
  } rec_t;

  function automatic logic [7:0] key_select(input logic [KEY_W-1:0] key,
                                            input logic [KEY_IDX_W-1:0] idx);
    return key[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: src/kxld_regs.sv
// Configuration register file on an APB-style port: two 128-bit keys and the
// comment switch. Depends on kxld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kxld_regs
  import kxld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [CFG_DATA_W-1:0] text_key_low;
  logic [CFG_DATA_W-1:0] text_key_high;
  logic [CFG_DATA_W-1:0] comment_key_low;
  logic [CFG_DATA_W-1:0] comment_key_high;
  logic                  comment_enable;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_key_low     <= '0;
      text_key_high    <= '0;
      comment_key_low  <= '0;
      comment_key_high <= '0;
      comment_enable   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEXT_KEY_LOW:     text_key_low     <= pwdata;
        REG_TEXT_KEY_HIGH:    text_key_high    <= pwdata;
        REG_COMMENT_KEY_LOW:  comment_key_low  <= pwdata;
        REG_COMMENT_KEY_HIGH: comment_key_high <= pwdata;
        REG_COMMENT_ENABLE:   comment_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_KEY_LOW:     prdata = text_key_low;
      REG_TEXT_KEY_HIGH:    prdata = text_key_high;
      REG_COMMENT_KEY_LOW:  prdata = comment_key_low;
      REG_COMMENT_KEY_HIGH: prdata = comment_key_high;
      REG_COMMENT_ENABLE:   prdata = {{(CFG_DATA_W-1){1'b0}}, comment_enable};
      default:              prdata = '0;
    endcase
  end

  assign cfg.text_key       = {text_key_high, text_key_low};
  assign cfg.comment_key    = {comment_key_high, comment_key_low};
  assign cfg.comment_enable = comment_enable;

endmodule

`default_nettype wire

// File: src/kxld_front.sv
// Front end: tracks line position, drops markers and stray bytes, and tags
// each remaining byte as pass or decode with its key index. Depends on kxld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kxld_front
  import kxld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_line,
  input  wire logic [15:0] line_length,
  output logic             rec_push,
  output rec_t             rec
);

  logic [15:0]          bytes_left;
  logic [15:0]          bytes_left_next;
  logic                 encrypted;
  logic                 encrypted_next;
  logic                 fresh;
  logic                 fresh_next;
  logic [KEY_IDX_W-1:0] key_index;
  logic [KEY_IDX_W-1:0] key_index_next;
  logic [15:0]          first_left;

  // zero length counts as one
  assign first_left = (line_length == 16'd0) ? 16'd0 : line_length - 16'd1;

  always_comb begin
    bytes_left_next = bytes_left;
    encrypted_next  = encrypted;
    fresh_next      = fresh;
    key_index_next  = key_index;
    rec_push        = 1'b0;
    rec.data        = data_byte;
    rec.last        = 1'b0;
    rec.decode      = 1'b0;
    rec.fresh       = fresh;
    rec.key_idx     = key_index;
    if (accept) begin
      if (first_of_line) begin
        bytes_left_next = first_left;
        if (data_byte == CHAR_MARKER) begin
          encrypted_next = 1'b1;
          fresh_next     = 1'b1;
          key_index_next = first_left[KEY_IDX_W-1:0];
        end else begin
          encrypted_next = 1'b0;
          fresh_next     = 1'b0;
          key_index_next = '0;
          rec_push       = 1'b1;
          rec.last       = (first_left == 16'd0);
        end
      end else if (bytes_left != 16'd0) begin
        bytes_left_next = bytes_left - 16'd1;
        rec_push        = 1'b1;
        rec.last        = (bytes_left == 16'd1);
        if (encrypted) begin
          rec.decode     = 1'b1;
          fresh_next     = 1'b0;
          key_index_next = key_index + KEY_IDX_W'(KEY_STEP);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      encrypted  <= 1'b0;
      fresh      <= 1'b0;
      key_index  <= '0;
    end else begin
      bytes_left <= bytes_left_next;
      encrypted  <= encrypted_next;
      fresh      <= fresh_next;
      key_index  <= key_index_next;
    end
  end

endmodule

`default_nettype wire

// File: src/kxld_queue.sv
// Short word queue between front and back end. Depends on kxld_pkg for the
// word type.
`timescale 1ns / 1ps
`default_nettype none

module kxld_queue
  import kxld_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire rec_t wr_data,
  input  wire logic rd,
  output rec_t      rd_data,
  output logic      valid,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign valid   = (count != '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_wr   = wr & ~full;
  assign do_rd   = rd & valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/kxld_back.sv
// Back end: decodes tagged words with the text or comment key, tracks the
// slash history, and holds the result in the output register. Depends on kxld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kxld_back
  import kxld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       rec_valid,
  input  wire rec_t       rec,
  output logic            rec_take,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last_of_line
);

  logic       out_valid;
  logic       in_comment;
  logic [7:0] prev;
  logic [7:0] prev_prev;
  logic       comment_now;
  logic [7:0] raw;
  logic [7:0] key;
  logic [7:0] dec;
  logic [7:0] dec_fix;
  logic [7:0] result;

  assign empty    = ~out_valid;
  assign rec_take = rec_valid & (~out_valid | pop);

  // a fresh line starts with cleared history, so no comment yet
  assign comment_now = ~rec.fresh & (in_comment | (cfg.comment_enable &
                       (prev_prev == CHAR_SLASH) & (prev == CHAR_SLASH)));
  assign raw     = (rec.data == CHAR_TAB) ? CODE_TAB : rec.data;
  assign key     = comment_now ? key_select(cfg.comment_key, rec.key_idx)
                               : key_select(cfg.text_key, rec.key_idx);
  assign dec     = (((raw - TEXT_BASE) ^ key) & TEXT_MASK) + TEXT_BASE;
  assign dec_fix = (dec == CODE_TAB) ? CHAR_TAB : dec;
  assign result  = (dec_fix == CODE_SPACE) ? CHAR_SPACE : dec_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      in_comment <= 1'b0;
      prev       <= '0;
      prev_prev  <= '0;
    end else begin
      if (rec_take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (rec_take && rec.decode) begin
        in_comment <= comment_now;
        prev       <= dec_fix;
        prev_prev  <= rec.fresh ? 8'h00 : prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      out_byte     <= rec.decode ? result : rec.data;
      last_of_line <= rec.last;
    end
  end

endmodule

`default_nettype wire

// File: src/keyed_xor_line_decoder_core.sv
// Keyed XOR line decoder, top level. Takes one byte per cycle while full is low and
// gives at most one byte per cycle. The front end classifies a taken byte
// combinationally and writes it into the word queue at the edge that takes it,
// then the back end loads it into the output register, from which it can be
// popped. The front end steps its line counter and key index for each byte,
// the back end does the key select and XOR for each byte, so the sustained
// rate is one byte per clock while pop keeps up. full rises when the
// QUEUE_DEPTH-word queue between the two ends is occupied and the output
// register is held. The '@' marker and stray bytes outside a line give no
// result. Keys and the comment switch are written over the APB port at byte
// addresses 0, 8, 16, 24 and 32; write them only while the block is idle,
// the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module keyed_xor_line_decoder_core
  import kxld_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  first_of_line,
  input  wire logic [15:0]           line_length,
  input  wire logic                  push,
  output logic                       full,
  output logic [7:0]                 out_byte,
  output logic                       last_of_line,
  output logic                       empty,
  input  wire logic                  pop
);

  cfg_t cfg;
  rec_t front_rec;
  rec_t back_rec;
  logic front_push;
  logic accept;
  logic q_valid;
  logic q_take;

  assign accept = push & ~full;

  kxld_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kxld_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .first_of_line (first_of_line),
    .line_length   (line_length),
    .rec_push      (front_push),
    .rec           (front_rec)
  );

  kxld_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_push),
    .wr_data (front_rec),
    .rd      (q_take),
    .rd_data (back_rec),
    .valid   (q_valid),
    .full    (full)
  );

  kxld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rec_valid    (q_valid),
    .rec          (back_rec),
    .rec_take     (q_take),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last_of_line (last_of_line)
  );

endmodule

`default_nettype wire

// File: test/keyed_xor_line_decoder_core_test.sv
// Testbench for keyed_xor_line_decoder_core: drives lines of bytes through the push/full
// side, programs the keys over APB and checks every popped word against a local decoder model.
// Depends on kxld_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module keyed_xor_line_decoder_core_test;
  import kxld_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } char_word_t;

  typedef enum int {LINE_PLAIN, LINE_RAW, LINE_TEXT} line_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic [7:0]            data_byte = 8'h00;
  logic                  first_of_line = 1'b0;
  logic [15:0]           line_length = 16'h0000;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            out_byte;
  logic                  last_of_line;
  logic                  empty;
  logic                  pop = 1'b0;

  // decoder model: configuration and line state
  logic [63:0] text_lo, text_hi, comment_lo, comment_hi;
  logic        comment_on;
  logic [3:0]  key_pos;
  logic        in_secret_line;
  logic        comment_mode;
  logic [7:0]  last_char, char_before;
  logic [15:0] chars_left;

  char_word_t pending_chars[$];
  int         mismatches = 0;
  int         line_words = 0;
  bit         push_steady = 1'b0;
  bit         pop_steady = 1'b0;
  int         pop_hold = 0;
  int         pop_roll;

  keyed_xor_line_decoder_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .data_byte(data_byte), .first_of_line(first_of_line), .line_length(line_length),
    .push(push), .full(full),
    .out_byte(out_byte), .last_of_line(last_of_line), .empty(empty), .pop(pop)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic comment_due();
    return comment_mode || (comment_on && char_before == CHAR_SLASH && last_char == CHAR_SLASH);
  endfunction

  function automatic logic [7:0] key_for(input logic comment_sel);
    logic [127:0] k;
    k = comment_sel ? {comment_hi, comment_lo} : {text_hi, text_lo};
    return k[{key_pos, 3'b000} +: 8];
  endfunction

  // Raw byte that decodes to want at the current key position of the line.
  function automatic logic [7:0] encode_char(input logic [7:0] want);
    logic [7:0] k;
    k = key_for(comment_due());
    return (((want - TEXT_BASE) ^ k) & TEXT_MASK) + TEXT_BASE;
  endfunction

  task automatic decode_char(input logic [7:0] raw, input logic first, input logic [15:0] len);
    logic [15:0] n;
    logic [7:0]  b, dec;
    n = (len == 16'd0) ? 16'd1 : len;
    if (first) begin
      chars_left = n - 16'd1;
      comment_mode = 1'b0;
      last_char = 8'h00;
      char_before = 8'h00;
      if (raw == CHAR_MARKER) begin
        in_secret_line = 1'b1;
        key_pos = chars_left[3:0];
      end else begin
        in_secret_line = 1'b0;
        key_pos = 4'd0;
        pending_chars.push_back('{raw, chars_left == 16'd0});
      end
    end else if (chars_left != 16'd0) begin
      chars_left = chars_left - 16'd1;
      if (!in_secret_line) begin
        pending_chars.push_back('{raw, chars_left == 16'd0});
      end else begin
        b = (raw == CHAR_TAB) ? CODE_TAB : raw;
        comment_mode = comment_due();
        dec = (((b - TEXT_BASE) ^ key_for(comment_mode)) & TEXT_MASK) + TEXT_BASE;
        if (dec == CODE_TAB) dec = CHAR_TAB;
        char_before = last_char;
        last_char = dec;
        key_pos = key_pos + 4'(KEY_STEP);
        pending_chars.push_back('{(dec == CODE_SPACE) ? CHAR_SPACE : dec, chars_left == 16'd0});
      end
    end
  endtask

  task automatic check_word();
    char_word_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h last %b", out_byte, last_of_line));
      return;
    end
    want = pending_chars.pop_front();
    if (out_byte !== want.data)
      report_mismatch($sformatf("out_byte %h, model %h", out_byte, want.data));
    if (last_of_line !== want.last)
      report_mismatch($sformatf("last_of_line %b, model %b (byte %h)", last_of_line,
                                want.last, want.data));
  endtask

  // Receiver: check each popped word, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_word();
      if (pop_steady) begin
        pop <= 1'b1;
      end else if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop_roll = $urandom_range(0, 99);
        if (pop_roll < 70) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          pop_hold = (pop_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  task automatic sender_gap();
    int r, gap;
    if (push_steady) return;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    push <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Called at a rising edge; returns at the edge that took the word, or after the random gap that follows it.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
    data_byte <= b;
    first_of_line <= first;
    line_length <= len;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (first || chars_left != 16'd0) line_words++;
    decode_char(b, first, len);
    sender_gap();
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TEXT_KEY_LOW:     text_lo = value;
      REG_TEXT_KEY_HIGH:    text_hi = value;
      REG_COMMENT_KEY_LOW:  comment_lo = value;
      REG_COMMENT_KEY_HIGH: comment_hi = value;
      REG_COMMENT_ENABLE:   comment_on = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] tl, input logic [63:0] th, input logic [63:0] cl,
                           input logic [63:0] ch, input logic en);
    wait_idle();
    apb_write(REG_TEXT_KEY_LOW, tl);
    apb_write(REG_TEXT_KEY_HIGH, th);
    apb_write(REG_COMMENT_KEY_LOW, cl);
    apb_write(REG_COMMENT_KEY_HIGH, ch);
    apb_write(REG_COMMENT_ENABLE, {63'd0, en});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input line_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      LINE_PLAIN: return 8'($urandom);
      LINE_RAW:   return (r < 20) ? CHAR_TAB : 8'($urandom);
      default: begin
        if (r < 30) return encode_char(CHAR_SLASH);
        if (r < 40) return CHAR_TAB;
        if (r < 45) return encode_char(CODE_TAB);
        if (r < 50) return encode_char(CODE_SPACE);
        if (r < 80) return encode_char(8'($urandom_range(8'h20, 8'h7e)));
        return 8'($urandom);
      end
    endcase
  endfunction

  task automatic send_line();
    int r, count;
    line_kind_t kind;
    logic [15:0] len_f;
    r = $urandom_range(0, 99);
    if (r < 85) count = $urandom_range(1, 16);
    else if (r < 97) count = $urandom_range(17, 64);
    else count = $urandom_range(200, 300);
    len_f = 16'(count);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      len_f = 16'($urandom);  // odd header length, line cut short or followed by stray bytes
    end else if (r < 8) begin
      count = $urandom_range(1, count);  // abandon with an early new line
    end else if (r < 10) begin
      len_f = 16'd0;
      count = 1;
    end
    r = $urandom_range(0, 99);
    kind = (r < 25) ? LINE_PLAIN : (r < 50) ? LINE_RAW : LINE_TEXT;
    send_byte((kind == LINE_PLAIN) ? 8'($urandom) : CHAR_MARKER, 1'b1, len_f);
    for (int i = 1; i < count; i++)
      send_byte(pick_byte(kind), 1'b0, 16'($urandom));
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 16'($urandom));
  endtask

  task automatic run_lines(input int n);
    int start;
    start = line_words;
    while (line_words - start < n) send_line();
  endtask

  task automatic test_directed();
    configure(64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0,
              64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    send_byte(8'h48, 1'b1, 16'd2);
    send_byte(8'hff, 1'b0, 16'hffff);
    send_byte(8'h00, 1'b1, 16'd0);          // zero length taken as one
    send_byte(8'h55, 1'b0, 16'd7);          // stray byte outside a line
    send_byte(CHAR_MARKER, 1'b1, 16'd1);    // marker-only line
    send_byte(CHAR_MARKER, 1'b1, 16'hffff);
    send_byte(CHAR_TAB, 1'b0, 16'd0);
    send_byte(encode_char(CODE_TAB), 1'b0, 16'd0);
    send_byte(encode_char(CODE_SPACE), 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'hff, 1'b0, 16'd0);
    send_byte(encode_char(CHAR_SLASH), 1'b0, 16'd0);
    send_byte(encode_char(CHAR_SLASH), 1'b0, 16'd0);
    send_byte(encode_char(8'h41), 1'b0, 16'd0);
    send_byte(8'h7f, 1'b0, 16'd0);
    // early new line drops the long one above
    send_byte(CHAR_MARKER, 1'b1, 16'd5);
    send_byte(encode_char(CHAR_SLASH), 1'b0, 16'd0);
    send_byte(encode_char(CHAR_SLASH), 1'b0, 16'd0);
    send_byte(encode_char(8'h78), 1'b0, 16'd0);
    send_byte(8'h20, 1'b0, 16'd0);
    send_byte(8'h80, 1'b1, 16'd3);
    send_byte(CHAR_MARKER, 1'b0, 16'd0);    // '@' inside a plain line passes through
    send_byte(CHAR_TAB, 1'b0, 16'd0);
  endtask

  task automatic test_zero_keys();
    configure(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    push_steady = 1'b1;
    pop_steady = 1'b1;
    run_lines(100);
    push_steady = 1'b0;
    pop_steady = 1'b0;
  endtask

  task automatic test_full_keys();
    configure('1, '1, '1, '1, 1'b1);
    run_lines(100);
  endtask

  task automatic test_random_keys();
    for (int s = 0; s < 4; s++) begin
      configure({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, s[0]);
      if (s == 1) begin
        run_lines(50);
        wait_idle();  // hold the sender until the queue has drained
        run_lines(50);
      end else begin
        run_lines(100);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_keys();
    test_full_keys();
    test_random_keys();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
